// File: src/ogh_pkg.sv
// Shared types and constants of the occupancy grid hit counter.
package ogh_pkg;

   localparam int SIZE_X_DEFAULT = 4;
   localparam int SIZE_Y_DEFAULT = 4;
   localparam int SIZE_Z_DEFAULT = 4;

   // A sweep reports at most this many freed cells.
   localparam int MAX_RESULTS = 64;
   localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] COUNT_MAX = 8'd255;
   localparam logic [7:0] DECAY_STEP_RESET = 8'd1;

   localparam logic [1:0] MODE_MARK_OCC  = 2'd0;
   localparam logic [1:0] MODE_MARK_FREE = 2'd1;
   localparam logic [1:0] MODE_DECAY     = 2'd2;
   localparam logic [1:0] MODE_READ      = 2'd3;

   typedef enum logic [2:0] {
      KIND_MARK_OCC,
      KIND_MARK_FREE,
      KIND_DECAY,
      KIND_READ,
      KIND_OUTSIDE
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] x;
      logic [3:0] y;
      logic [3:0] z;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } chan_type;

endpackage

// File: src/ogh_req_if.sv
// Request channel of the occupancy grid hit counter.
interface ogh_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [3:0] cell_x;
   logic [3:0] cell_y;
   logic [3:0] cell_z;

   modport source (output valid, mode, cell_x, cell_y, cell_z, input ready);
   modport sink (input valid, mode, cell_x, cell_y, cell_z, output ready);
endinterface

// File: src/ogh_rsp_if.sv
// Response channel of the occupancy grid hit counter.
interface ogh_rsp_if;
   logic       valid;
   logic       ready;
   logic       changed;
   logic [3:0] change_x;
   logic [3:0] change_y;
   logic [3:0] change_z;
   logic       occupied;
   logic       last;

   modport source (output valid, changed, change_x, change_y, change_z, occupied, last,
                   input ready);
   modport sink (input valid, changed, change_x, change_y, change_z, occupied, last,
                 output ready);
endinterface

// File: src/ogh_csr_if.sv
// Configuration write channel of the occupancy grid hit counter.
interface ogh_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] decay_step;

   modport source (output valid, decay_step, input ready);
   modport sink (input valid, decay_step, output ready);
endinterface

// File: src/ogh_front.sv
// Front end: accepts requests and classifies them by operation and grid bounds.
module ogh_front #(
   parameter int SizeX = ogh_pkg::SIZE_X_DEFAULT,
   parameter int SizeY = ogh_pkg::SIZE_Y_DEFAULT,
   parameter int SizeZ = ogh_pkg::SIZE_Z_DEFAULT
) (
   ogh_req_if.sink         req_if,
   input  logic            queue_full,
   output ogh_pkg::chan_type push
);

   logic in_grid;

   assign in_grid = ({1'b0, req_if.cell_x} < 5'(SizeX))
                 && ({1'b0, req_if.cell_y} < 5'(SizeY))
                 && ({1'b0, req_if.cell_z} < 5'(SizeZ));

   assign req_if.ready = !queue_full;

   always_comb begin
      push.valid  = req_if.valid && !queue_full;
      push.item.x = req_if.cell_x;
      push.item.y = req_if.cell_y;
      push.item.z = req_if.cell_z;
      unique case (req_if.mode)
         ogh_pkg::MODE_MARK_OCC:  push.item.kind = ogh_pkg::KIND_MARK_OCC;
         ogh_pkg::MODE_MARK_FREE: push.item.kind = ogh_pkg::KIND_MARK_FREE;
         ogh_pkg::MODE_DECAY:     push.item.kind = ogh_pkg::KIND_DECAY;
         ogh_pkg::MODE_READ:      push.item.kind = ogh_pkg::KIND_READ;
         default:                 push.item.kind = ogh_pkg::KIND_READ;
      endcase
      // A sweep ignores the coordinates, so only cell operations can fall outside.
      if (req_if.mode != ogh_pkg::MODE_DECAY && !in_grid) begin
         push.item.kind = ogh_pkg::KIND_OUTSIDE;
      end
   end

endmodule

// File: src/ogh_queue.sv
// Short queue of classified requests between the front and back ends.
module ogh_queue (
   input  logic              clock,
   input  logic              reset,
   input  ogh_pkg::chan_type push,
   output logic              full,
   output ogh_pkg::chan_type head,
   input  logic              pop
);

   localparam int PtrW = (ogh_pkg::QUEUE_DEPTH > 1) ? $clog2(ogh_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(ogh_pkg::QUEUE_DEPTH + 1);

   ogh_pkg::item_type entry_ff [ogh_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = count_ff == CntW'(ogh_pkg::QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.item  = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(ogh_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(ogh_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

// File: src/ogh_back.sv
// Back end: hit count memory, read-modify-write of cells, decay sweep and response register.
module ogh_back #(
   parameter int SizeX = ogh_pkg::SIZE_X_DEFAULT,
   parameter int SizeY = ogh_pkg::SIZE_Y_DEFAULT,
   parameter int SizeZ = ogh_pkg::SIZE_Z_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  ogh_pkg::chan_type head,
   output logic              pop,
   input  logic [7:0]        decay_step,
   ogh_rsp_if.source         rsp_if
);

   localparam int Cells = SizeX * SizeY * SizeZ;
   localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1;
   localparam int ResW  = ogh_pkg::RESULT_CNT_W;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_CELL  = 5'b00100,
      ST_SWEEP = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   logic [7:0] count_mem [Cells];

   state_type         state_ff, state_in;
   logic [AddrW-1:0]  addr_ff, addr_in;
   ogh_pkg::item_type item_ff, item_in;
   logic [3:0]        sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [7:0]        rd_data_ff;
   logic              pend_valid_ff, pend_valid_in;
   logic [3:0]        pend_x_ff, pend_x_in, pend_y_ff, pend_y_in, pend_z_ff, pend_z_in;
   logic [ResW-1:0]   n_ff, n_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_changed_ff, rsp_changed_in;
   logic [3:0]        rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic              rsp_occ_ff, rsp_occ_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              mem_we, mem_re;
   logic [AddrW-1:0]  mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;
   logic              out_free, out_load;
   logic [31:0]       head_lin;
   logic [AddrW-1:0]  head_addr;
   logic [7:0]        decayed;
   logic              freed, report, stall, last_cell;

   assign head_lin  = (32'(head.item.x) * 32'(SizeY) + 32'(head.item.y)) * 32'(SizeZ)
                    + 32'(head.item.z);
   assign head_addr = head_lin[AddrW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_if.ready;

   // Sweep arithmetic on the count of the cell at addr_ff.
   assign decayed   = (rd_data_ff > decay_step) ? rd_data_ff - decay_step : 8'd0;
   assign freed     = (rd_data_ff != 8'd0) && (decayed == 8'd0);
   assign report    = freed && (n_ff < ResW'(ogh_pkg::MAX_RESULTS));
   assign stall     = report && pend_valid_ff && !out_free;
   assign last_cell = addr_ff == AddrW'(Cells - 1);

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      item_in        = item_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      sz_in          = sz_ff;
      pend_valid_in  = pend_valid_ff;
      pend_x_in      = pend_x_ff;
      pend_y_in      = pend_y_ff;
      pend_z_in      = pend_z_ff;
      n_in           = n_ff;
      pop            = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = addr_ff;
      mem_wdata      = 8'd0;
      mem_re         = 1'b0;
      mem_raddr      = head_addr;
      out_load       = 1'b0;
      rsp_changed_in = rsp_changed_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_z_in       = rsp_z_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (last_cell) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               item_in = head.item;
               if (head.item.kind == ogh_pkg::KIND_DECAY) begin
                  mem_re        = 1'b1;
                  mem_raddr     = '0;
                  addr_in       = '0;
                  sx_in         = 4'd0;
                  sy_in         = 4'd0;
                  sz_in         = 4'd0;
                  n_in          = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_SWEEP;
               end else begin
                  mem_re   = head.item.kind != ogh_pkg::KIND_OUTSIDE;
                  addr_in  = head_addr;
                  state_in = ST_CELL;
               end
            end
         end
         ST_CELL: begin
            if (out_free) begin
               out_load       = 1'b1;
               rsp_x_in       = item_ff.x;
               rsp_y_in       = item_ff.y;
               rsp_z_in       = item_ff.z;
               rsp_last_in    = 1'b1;
               rsp_changed_in = 1'b0;
               rsp_occ_in     = rd_data_ff != 8'd0;
               unique case (item_ff.kind)
                  ogh_pkg::KIND_MARK_OCC: begin
                     mem_we         = 1'b1;
                     mem_wdata      = (rd_data_ff == ogh_pkg::COUNT_MAX) ? rd_data_ff
                                                                        : rd_data_ff + 8'd1;
                     rsp_changed_in = rd_data_ff == 8'd0;
                     rsp_occ_in     = 1'b1;
                  end
                  ogh_pkg::KIND_MARK_FREE: begin
                     mem_we         = 1'b1;
                     mem_wdata      = (rd_data_ff == 8'd0) ? 8'd0 : rd_data_ff - 8'd1;
                     rsp_changed_in = rd_data_ff == 8'd1;
                     rsp_occ_in     = rd_data_ff > 8'd1;
                  end
                  ogh_pkg::KIND_OUTSIDE: begin
                     rsp_occ_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (!stall) begin
               mem_we    = 1'b1;
               mem_wdata = decayed;
               if (report) begin
                  if (pend_valid_ff) begin
                     out_load       = 1'b1;
                     rsp_changed_in = 1'b1;
                     rsp_x_in       = pend_x_ff;
                     rsp_y_in       = pend_y_ff;
                     rsp_z_in       = pend_z_ff;
                     rsp_occ_in     = 1'b0;
                     rsp_last_in    = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_x_in     = sx_ff;
                  pend_y_in     = sy_ff;
                  pend_z_in     = sz_ff;
                  n_in          = n_ff + 1'b1;
               end
               if (last_cell) begin
                  state_in = ST_FLUSH;
               end else begin
                  addr_in   = addr_ff + 1'b1;
                  mem_re    = 1'b1;
                  mem_raddr = addr_ff + 1'b1;
                  if (sz_ff == 4'(SizeZ - 1)) begin
                     sz_in = 4'd0;
                     if (sy_ff == 4'(SizeY - 1)) begin
                        sy_in = 4'd0;
                        sx_in = sx_ff + 4'd1;
                     end else begin
                        sy_in = sy_ff + 4'd1;
                     end
                  end else begin
                     sz_in = sz_ff + 4'd1;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load       = 1'b1;
               rsp_changed_in = pend_valid_ff;
               rsp_x_in       = pend_valid_ff ? pend_x_ff : 4'd0;
               rsp_y_in       = pend_valid_ff ? pend_y_ff : 4'd0;
               rsp_z_in       = pend_valid_ff ? pend_z_ff : 4'd0;
               rsp_occ_in     = 1'b0;
               rsp_last_in    = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         pend_valid_ff <= 1'b0;
         n_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         pend_valid_ff <= pend_valid_in;
         n_ff          <= n_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      sx_ff          <= sx_in;
      sy_ff          <= sy_in;
      sz_ff          <= sz_in;
      pend_x_ff      <= pend_x_in;
      pend_y_ff      <= pend_y_in;
      pend_z_ff      <= pend_z_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_z_ff       <= rsp_z_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Hit count memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= count_mem[mem_raddr];
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.changed  = rsp_changed_ff;
   assign rsp_if.change_x = rsp_x_ff;
   assign rsp_if.change_y = rsp_y_ff;
   assign rsp_if.change_z = rsp_z_ff;
   assign rsp_if.occupied = rsp_occ_ff;
   assign rsp_if.last     = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !pop)
      else $error("request taken from the queue during the clearing pass");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("response register overwritten while still held");

   a_pending_counted: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> n_ff != '0)
      else $error("pending change without a result count");

   a_sweep_ends_in_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && !stall && last_cell) |=> state_ff == ST_FLUSH)
      else $error("sweep did not close with its final response");
`endif

endmodule

// File: src/occupancy_grid_hit_counter.sv
// Top level of the occupancy grid hit counter.
//
// Requests arrive on req_if (mode, cell_x, cell_y, cell_z) and responses leave on rsp_if,
// both with valid/ready; a request or response moves at a clock edge where both are high.
// csr_if writes the decay step; it is always ready and should be used only while idle.
// Mark-occupied, mark-free and read requests each give one response. The back end reads
// the count of an in-grid cell, then writes it back for a mark and loads the response
// register, and takes no new request until that response has been loaded. A decay sweep
// walks every cell once, one cell a cycle unless a held response stalls it, through the
// hit count memory with its one write and one registered read port, and gives one
// response per freed cell (at most 64) or a single no-change response.
// The front end classifies requests into a two-entry queue, so requests keep being taken,
// until the queue is full, while the back end is busy or a response waits to be taken.
// After reset the hit counts are cleared one cell a cycle; during this pass requests may
// queue but are not processed, and the decay step resets to 1.
// A stalled receiver holds the response register and, once the queue is full, the request
// channel; no response is dropped.
module occupancy_grid_hit_counter #(
   parameter int SIZE_X = ogh_pkg::SIZE_X_DEFAULT,
   parameter int SIZE_Y = ogh_pkg::SIZE_Y_DEFAULT,
   parameter int SIZE_Z = ogh_pkg::SIZE_Z_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ogh_req_if.sink   req_if,
   ogh_rsp_if.source rsp_if,
   ogh_csr_if.sink   csr_if
);

   // Decay step register, written through the configuration channel.
   logic [7:0] decay_step_ff;

   ogh_pkg::chan_type push;
   ogh_pkg::chan_type head;
   logic              queue_full;
   logic              pop;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_step_ff <= ogh_pkg::DECAY_STEP_RESET;
      end else if (csr_if.valid) begin
         decay_step_ff <= csr_if.decay_step;
      end
   end

   // Front end: takes requests and tags them by operation and grid bounds.
   ogh_front #(
      .SizeX (SIZE_X),
      .SizeY (SIZE_Y),
      .SizeZ (SIZE_Z)
   ) u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push)
   );

   // Decoupling queue between the two ends.
   ogh_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // Back end: hit count memory, cell updates, decay sweep and the response register.
   ogh_back #(
      .SizeX (SIZE_X),
      .SizeY (SIZE_Y),
      .SizeZ (SIZE_Z)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .decay_step (decay_step_ff),
      .rsp_if     (rsp_if)
   );

endmodule

// File: bench/tb_occupancy_grid_hit_counter.sv
// Self-checking testbench for the occupancy grid hit counter: directed table, then random phases.
`timescale 1ns / 1ps

module tb_occupancy_grid_hit_counter;

   localparam int GRID_X = ogh_pkg::SIZE_X_DEFAULT;
   localparam int GRID_Y = ogh_pkg::SIZE_Y_DEFAULT;
   localparam int GRID_Z = ogh_pkg::SIZE_Z_DEFAULT;
   localparam int CELLS = GRID_X * GRID_Y * GRID_Z;

   localparam logic [1:0] MARK_OCC  = ogh_pkg::MODE_MARK_OCC;
   localparam logic [1:0] MARK_FREE = ogh_pkg::MODE_MARK_FREE;
   localparam logic [1:0] SWEEP     = ogh_pkg::MODE_DECAY;
   localparam logic [1:0] READ_CELL = ogh_pkg::MODE_READ;

   // A sweep holds the back end while it walks every cell, so this many quiet cycles after
   // the last response are enough for the block to settle before a register write.
   localparam int SETTLE_CYCLES = CELLS + 8;

   // Longest stretch without any handshake that a correct run can show: the clearing pass
   // after reset, a full sweep, a stalled receiver and the pause before a register write
   // all stay well below this.
   localparam int QUIET_LIMIT = 3000;

   // One response as the block reports it.
   typedef struct packed {
      logic       changed;
      logic [3:0] x;
      logic [3:0] y;
      logic [3:0] z;
      logic       occupied;
      logic       last;
   } grid_report_type;

   // One row of the opening table. Where typed is set, want is the response to expect;
   // otherwise the response comes from the grid model below.
   typedef struct packed {
      logic [1:0]      mode;
      logic [3:0]      x;
      logic [3:0]      y;
      logic [3:0]      z;
      bit              typed;
      grid_report_type want;
   } plan_row_type;

   localparam grid_report_type NO_REPORT = '0;
   localparam int PLAN_ROWS = 23;

   // The opening table runs with the decay step at its reset value of one.
   localparam plan_row_type OPENING_PLAN [PLAN_ROWS] = '{
      // A fresh grid reads as free, both inside and far outside its bounds.
      '{READ_CELL, 4'd0,  4'd0,  4'd0,  1'b1, '{1'b0, 4'd0,  4'd0,  4'd0,  1'b0, 1'b1}},
      '{READ_CELL, 4'd15, 4'd15, 4'd15, 1'b1, '{1'b0, 4'd15, 4'd15, 4'd15, 1'b0, 1'b1}},
      // The first mark flips the cell; the second only raises its count.
      '{MARK_OCC,  4'd0,  4'd0,  4'd0,  1'b1, '{1'b1, 4'd0,  4'd0,  4'd0,  1'b1, 1'b1}},
      '{MARK_OCC,  4'd0,  4'd0,  4'd0,  1'b1, '{1'b0, 4'd0,  4'd0,  4'd0,  1'b1, 1'b1}},
      '{READ_CELL, 4'd0,  4'd0,  4'd0,  1'b0, NO_REPORT},
      '{MARK_FREE, 4'd0,  4'd0,  4'd0,  1'b0, NO_REPORT},
      '{MARK_FREE, 4'd0,  4'd0,  4'd0,  1'b0, NO_REPORT},
      // Freeing a cell whose count is already zero changes nothing.
      '{MARK_FREE, 4'd0,  4'd0,  4'd0,  1'b1, '{1'b0, 4'd0,  4'd0,  4'd0,  1'b0, 1'b1}},
      // A sweep over an empty grid gives a single no-change response at the origin.
      '{SWEEP,     4'd15, 4'd15, 4'd15, 1'b1, '{1'b0, 4'd0,  4'd0,  4'd0,  1'b0, 1'b1}},
      // Each coordinate just past the grid edge is ignored and reads as free.
      '{MARK_OCC,  4'd4,  4'd0,  4'd0,  1'b1, '{1'b0, 4'd4,  4'd0,  4'd0,  1'b0, 1'b1}},
      '{MARK_FREE, 4'd0,  4'd4,  4'd0,  1'b1, '{1'b0, 4'd0,  4'd4,  4'd0,  1'b0, 1'b1}},
      '{READ_CELL, 4'd0,  4'd0,  4'd4,  1'b1, '{1'b0, 4'd0,  4'd0,  4'd4,  1'b0, 1'b1}},
      '{MARK_OCC,  4'd3,  4'd3,  4'd3,  1'b1, '{1'b1, 4'd3,  4'd3,  4'd3,  1'b1, 1'b1}},
      '{MARK_OCC,  4'd3,  4'd0,  4'd2,  1'b0, NO_REPORT},
      '{MARK_OCC,  4'd3,  4'd0,  4'd2,  1'b0, NO_REPORT},
      '{MARK_OCC,  4'd1,  4'd2,  4'd3,  1'b0, NO_REPORT},
      '{MARK_OCC,  4'd0,  4'd3,  4'd1,  1'b0, NO_REPORT},
      '{READ_CELL, 4'd3,  4'd3,  4'd3,  1'b0, NO_REPORT},
      // This sweep frees three cells and leaves the twice-marked one at a count of one.
      '{SWEEP,     4'd0,  4'd0,  4'd0,  1'b0, NO_REPORT},
      '{READ_CELL, 4'd3,  4'd0,  4'd2,  1'b0, NO_REPORT},
      '{SWEEP,     4'd8,  4'd8,  4'd8,  1'b0, NO_REPORT},
      '{MARK_OCC,  4'd15, 4'd0,  4'd0,  1'b1, '{1'b0, 4'd15, 4'd0,  4'd0,  1'b0, 1'b1}},
      '{MARK_FREE, 4'd0,  4'd15, 4'd0,  1'b1, '{1'b0, 4'd0,  4'd15, 4'd0,  1'b0, 1'b1}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   ogh_req_if req_ch ();
   ogh_rsp_if rsp_ch ();
   ogh_csr_if csr_ch ();

   occupancy_grid_hit_counter u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #5 clock = ~clock;

   // The testbench's own copy of the grid, kept in step with every accepted request.
   logic [7:0]   grid_counts [CELLS];
   logic         grid_occupied [CELLS];
   logic [7:0]   decay_amount;

   // Responses still owed by the block, oldest first.
   grid_report_type awaited_reports [$];

   int unsigned  mismatches;
   int unsigned  requests_sent;
   int unsigned  sweeps_sent;
   int unsigned  responses_seen;
   int unsigned  flips_seen;
   int unsigned  quiet_cycles;
   bit           req_calm;
   bit           rsp_calm;

   function automatic int cell_index(input int x, input int y, input int z);
      return (x * GRID_Y + y) * GRID_Z + z;
   endfunction

   // Adds one response to the end of the owed list.
   function automatic void owe_report(input grid_report_type rep);
      awaited_reports = {awaited_reports, rep};
   endfunction

   // Applies one accepted request to the grid copy and queues the responses it causes.
   task automatic apply_grid_request(input logic [1:0] mode, input logic [3:0] x,
                                     input logic [3:0] y, input logic [3:0] z);
      int              idx;
      int              freed;
      logic [7:0]      count;
      grid_report_type report;
      freed = 0;
      if (mode == SWEEP) begin
         // Visit order matters: x outermost and z innermost, as the block walks its memory.
         for (int cx = 0; cx < GRID_X; cx++) begin
            for (int cy = 0; cy < GRID_Y; cy++) begin
               for (int cz = 0; cz < GRID_Z; cz++) begin
                  idx = cell_index(cx, cy, cz);
                  count = grid_counts[idx];
                  if (count != 8'd0) begin
                     count = (count > decay_amount) ? count - decay_amount : 8'd0;
                     grid_counts[idx] = count;
                     if (count == 8'd0 && grid_occupied[idx]) begin
                        grid_occupied[idx] = 1'b0;
                        if (freed < ogh_pkg::MAX_RESULTS) begin
                           report = '{1'b1, 4'(cx), 4'(cy), 4'(cz), 1'b0, 1'b0};
                           owe_report(report);
                           freed++;
                        end
                     end
                  end
               end
            end
         end
         if (freed == 0) begin
            owe_report('{1'b0, 4'd0, 4'd0, 4'd0, 1'b0, 1'b1});
         end else begin
            awaited_reports[awaited_reports.size() - 1].last = 1'b1;
         end
      end else if (x >= GRID_X || y >= GRID_Y || z >= GRID_Z) begin
         owe_report('{1'b0, x, y, z, 1'b0, 1'b1});
      end else begin
         idx = cell_index(x, y, z);
         count = grid_counts[idx];
         report = '{1'b0, x, y, z, 1'b0, 1'b1};
         if (mode == MARK_OCC) begin
            // The count saturates rather than wrapping.
            if (count != ogh_pkg::COUNT_MAX) count = count + 8'd1;
            grid_counts[idx] = count;
            if (count == 8'd1) begin
               grid_occupied[idx] = 1'b1;
               report.changed = 1'b1;
            end
         end else if (mode == MARK_FREE) begin
            if (count != 8'd0) count = count - 8'd1;
            grid_counts[idx] = count;
            if (count == 8'd0 && grid_occupied[idx]) begin
               grid_occupied[idx] = 1'b0;
               report.changed = 1'b1;
            end
         end
         report.occupied = grid_occupied[idx];
         owe_report(report);
      end
   endtask

   // Offers one request after a random gap and returns on the falling edge after it is taken.
   task automatic send_request(input logic [1:0] mode, input logic [3:0] x,
                               input logic [3:0] y, input logic [3:0] z);
      int gap;
      if ($urandom_range(0, 15) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.mode   = mode;
      req_ch.cell_x = x;
      req_ch.cell_y = y;
      req_ch.cell_z = z;
      do @(posedge clock); while (!req_ch.ready);
      apply_grid_request(mode, x, y, z);
      requests_sent++;
      if (mode == SWEEP) sweeps_sent++;
      @(negedge clock);
   endtask

   // Mostly in-grid requests, four in ten of all on a corner of eight cells so that counts
   // build up; one in ten has arbitrary coordinates that may fall outside.
   task automatic send_random_request();
      int          pick;
      logic [1:0]  mode;
      logic [3:0]  x;
      logic [3:0]  y;
      logic [3:0]  z;
      pick = $urandom_range(0, 99);
      if (pick < 45) mode = MARK_OCC;
      else if (pick < 70) mode = MARK_FREE;
      else if (pick < 86) mode = READ_CELL;
      else mode = SWEEP;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         x = 4'($urandom_range(0, 15));
         y = 4'($urandom_range(0, 15));
         z = 4'($urandom_range(0, 15));
      end else if (pick < 5) begin
         x = 4'($urandom_range(0, 1));
         y = 4'($urandom_range(0, 1));
         z = 4'($urandom_range(0, 1));
      end else begin
         x = 4'($urandom_range(0, GRID_X - 1));
         y = 4'($urandom_range(0, GRID_Y - 1));
         z = 4'($urandom_range(0, GRID_Z - 1));
      end
      send_request(mode, x, y, z);
   endtask

   // Waits until every owed response has come and the back end has had time to go quiet.
   task automatic settle_grid();
      req_ch.valid = 1'b0;
      while (awaited_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the decay step; only called while the block is idle.
   task automatic write_decay_step(input logic [7:0] step);
      csr_ch.valid      = 1'b1;
      csr_ch.decay_step = step;
      do @(posedge clock); while (!csr_ch.ready);
      decay_amount = step;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Response side: stalls at random, then compares each accepted response with the oldest
   // one owed.
   initial begin : report_sink
      grid_report_type got;
      grid_report_type want;
      int              stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got = '{rsp_ch.changed, rsp_ch.change_x, rsp_ch.change_y, rsp_ch.change_z,
                 rsp_ch.occupied, rsp_ch.last};
         responses_seen++;
         if (got.changed) flips_seen++;
         if (awaited_reports.size() == 0) begin
            mismatches++;
            $display("%0t ns: response with none owed, expected nothing, got changed=%0d",
                     $time, got.changed);
            $display("   cell=(%0d,%0d,%0d) occupied=%0d last=%0d",
                     got.x, got.y, got.z, got.occupied, got.last);
         end else begin
            want = awaited_reports.pop_front();
            check_field("changed", want.changed, got.changed);
            check_field("change_x", want.x, got.x);
            check_field("change_y", want.y, got.y);
            check_field("change_z", want.z, got.z);
            check_field("occupied", want.occupied, got.occupied);
            check_field("last", want.last, got.last);
         end
         @(negedge clock);
      end
   end

   // Watchdog: a run in which no handshake happens for too long has hung.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                   (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      req_ch.valid      = 1'b0;
      req_ch.mode       = MARK_OCC;
      req_ch.cell_x     = 4'd0;
      req_ch.cell_y     = 4'd0;
      req_ch.cell_z     = 4'd0;
      csr_ch.valid      = 1'b0;
      csr_ch.decay_step = 8'd0;
      mismatches        = 0;
      requests_sent     = 0;
      sweeps_sent       = 0;
      responses_seen    = 0;
      flips_seen        = 0;
      req_calm          = 1'b0;
      rsp_calm          = 1'b0;
      decay_amount      = ogh_pkg::DECAY_STEP_RESET;
      for (int i = 0; i < CELLS; i++) begin
         grid_counts[i]   = 8'd0;
         grid_occupied[i] = 1'b0;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Opening table. Requests may queue while the block clears its memory after reset.
      for (int i = 0; i < PLAN_ROWS; i++) begin
         send_request(OPENING_PLAN[i].mode, OPENING_PLAN[i].x, OPENING_PLAN[i].y,
                      OPENING_PLAN[i].z);
         if (OPENING_PLAN[i].typed) begin
            // The typed response replaces the one just worked out for this row.
            awaited_reports[awaited_reports.size() - 1] = OPENING_PLAN[i].want;
         end
      end
      settle_grid();

      // A step of zero leaves every count as it is, so sweeps free nothing.
      write_decay_step(8'd0);
      repeat (40) send_random_request();
      settle_grid();

      // The largest step frees every occupied cell at once. Filling the whole grid first
      // makes one sweep report all sixty-four cells.
      write_decay_step(8'd255);
      repeat (35) send_random_request();
      for (int cx = 0; cx < GRID_X; cx++)
         for (int cy = 0; cy < GRID_Y; cy++)
            for (int cz = 0; cz < GRID_Z; cz++)
               send_request(MARK_OCC, 4'(cx), 4'(cy), 4'(cz));
      send_request(SWEEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)));
      repeat (8) send_random_request();
      settle_grid();

      write_decay_step(8'($urandom_range(2, 254)));
      repeat (60) send_random_request();
      settle_grid();

      // Slow sweeps with a step of one let counts build up over several marks.
      write_decay_step(8'd1);
      repeat (50) send_random_request();
      settle_grid();

      write_decay_step(8'($urandom_range(1, 255)));
      repeat (28) send_random_request();
      send_request(SWEEP, 4'd0, 4'd0, 4'd0);
      settle_grid();

      if (awaited_reports.size() != 0) begin
         mismatches++;
         $display("%0t ns: %0d responses never arrived", $time, awaited_reports.size());
      end
      $display("Sent %0d requests including %0d decay sweeps; checked %0d responses.",
               requests_sent, sweeps_sent, responses_seen);
      $display("%0d responses were cell flips; decay steps covered zero, one, the maximum %s",
               flips_seen, "and random values.");
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: occupancy_grid_hit_counter.f
src/ogh_pkg.sv
src/ogh_req_if.sv
src/ogh_rsp_if.sv
src/ogh_csr_if.sv
src/ogh_front.sv
src/ogh_queue.sv
src/ogh_back.sv
src/occupancy_grid_hit_counter.sv
bench/tb_occupancy_grid_hit_counter.sv
